// ===== design/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the websocket frame deframer
// used by every module of the design folder except wsd_in_stage, no dependencies
`default_nettype none

package wsd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // extended length byte counts, minus one
  localparam logic [2:0] HDR_CNT_EXT16 = 3'd1;
  localparam logic [2:0] HDR_CNT_EXT64 = 3'd7;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_kind;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== design/wsd_in_stage.sv =====
// wsd_in_stage: input register that holds one received byte
// uses no package items
`default_nettype none

module wsd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  // room when empty or when the held byte is consumed this cycle
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = vld_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

// ===== design/wsd_parser.sv =====
// wsd_parser: frame header parser, length counter and payload unmasking
// depends on wsd_pkg for phase codes, opcodes and the result struct
`default_nettype none

module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t res_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  wsd_pkg::phase_e        phase_q, phase_d;
  logic [3:0]             op_q, op_d;
  logic                   mask_q, mask_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [1:0]             pos_q, pos_d;
  logic [7:0]             key_q [4];
  logic [7:0]             key_d [4];

  logic [6:0]             code;
  logic [LENGTH_BITS-1:0] len_val;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   mp_val;
  logic                   len_end;
  logic                   hdr_end;
  logic                   last;
  logic [2:0]             cnt_inc;
  logic [7:0]             data;

  assign code    = byte_i[6:0];
  assign cnt_inc = cnt_q + 3'd1;
  assign rem_dec = (rem_q != '0) ? rem_q - LENGTH_BITS'(1) : rem_q;
  assign last    = (rem_dec == '0);
  assign data    = mask_q ? (byte_i ^ key_q[pos_q]) : byte_i;

  always_comb begin
    phase_d     = phase_q;
    op_d        = op_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    key_d       = key_q;
    len_val     = rem_q;
    mp_val      = mask_q;
    len_end     = 1'b0;
    hdr_end     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      wsd_pkg::PH_HDR1: begin
        mask_d = byte_i[7];
        if (code == wsd_pkg::LEN_CODE_EXT16 || code == wsd_pkg::LEN_CODE_EXT64) begin
          rem_d   = '0;
          cnt_d   = (code == wsd_pkg::LEN_CODE_EXT16) ? wsd_pkg::HDR_CNT_EXT16
                                                      : wsd_pkg::HDR_CNT_EXT64;
          phase_d = wsd_pkg::PH_EXT;
        end else begin
          len_val = {{(LENGTH_BITS-7){1'b0}}, code};
          mp_val  = byte_i[7];
          len_end = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        // saturate once the next shift would drop set bits
        if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
          len_val = LenMax;
        end else begin
          len_val = {rem_q[LENGTH_BITS-9:0], byte_i};
        end
        rem_d = len_val;
        if (cnt_q != 3'd0) begin
          cnt_d = cnt_q - 3'd1;
        end else begin
          len_end = 1'b1;
        end
      end
      wsd_pkg::PH_MASK: begin
        key_d[cnt_q[1:0]] = byte_i;
        cnt_d             = cnt_inc;
        if (cnt_inc[2]) begin
          cnt_d   = 3'd0;
          hdr_end = 1'b1;
        end
      end
      wsd_pkg::PH_DATA: begin
        pos_d = pos_q + 2'd1;
        rem_d = rem_dec;
        if (last) begin
          phase_d = wsd_pkg::PH_HDR0;
        end
        if (op_q == wsd_pkg::OP_TEXT) begin
          res_valid_o         = 1'b1;
          res_o.payload_byte  = data;
          res_o.last_of_frame = last;
        end else if (op_q == wsd_pkg::OP_CLOSE && last) begin
          res_valid_o         = 1'b1;
          res_o.frame_kind    = 1'b1;
          res_o.last_of_frame = 1'b1;
        end
      end
      default: begin
        op_d    = byte_i[3:0];
        phase_d = wsd_pkg::PH_HDR1;
      end
    endcase

    if (len_end) begin
      rem_d = len_val;
      if (mp_val) begin
        cnt_d   = 3'd0;
        phase_d = wsd_pkg::PH_MASK;
      end else begin
        hdr_end = 1'b1;
      end
    end

    if (hdr_end) begin
      pos_d = 2'd0;
      if (len_val != '0) begin
        phase_d = wsd_pkg::PH_DATA;
      end else begin
        // zero-length frame ends on its last header byte
        phase_d = wsd_pkg::PH_HDR0;
        if (op_q == wsd_pkg::OP_TEXT) begin
          res_valid_o         = 1'b1;
          res_o.last_of_frame = 1'b1;
          res_o.empty_frame   = 1'b1;
        end else if (op_q == wsd_pkg::OP_CLOSE) begin
          res_valid_o         = 1'b1;
          res_o.frame_kind    = 1'b1;
          res_o.last_of_frame = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PH_HDR0;
      op_q    <= 4'd0;
      mask_q  <= 1'b0;
      cnt_q   <= 3'd0;
      rem_q   <= '0;
      pos_q   <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= 8'd0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      key_q   <= key_d;
    end
  end

  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.frame_kind |->
      res_o.last_of_frame && res_o.payload_byte == 8'd0 && !res_o.empty_frame)
    else $error("close marker without last mark or with payload");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.empty_frame |->
      res_o.last_of_frame && !res_o.frame_kind && phase_q != wsd_pkg::PH_DATA)
    else $error("empty frame mark outside a zero-length text header");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.last_of_frame |=> phase_q == wsd_pkg::PH_HDR0)
    else $error("parser not back at frame start after last result");

endmodule

`default_nettype wire

// ===== design/wsd_out_stage.sv =====
// wsd_out_stage: result register on the output channel
// depends on wsd_pkg for the result struct
`default_nettype none

module wsd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  wsd_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wsd_pkg::result_t res_o
);

  logic             vld_q, vld_d;
  wsd_pkg::result_t res_q;

  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = res_valid_i;
    end else if (ready_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer.sv =====
// websocket_frame_deframer: top level, input register, parser, result register
// depends on wsd_pkg, wsd_in_stage, wsd_parser and wsd_out_stage
`default_nettype none

// Takes one received byte per cycle unless stalled, and parses WebSocket frame headers
// (opcode, mask bit, 7-bit length, 16- or 64-bit extended length, mask key),
// unmasking payload bytes as they pass. Text payload bytes come out one per
// request with a last mark, a zero-length text frame gives one empty mark,
// and a close frame gives one marker at its end; other frames are dropped.
// Each byte passes from the input register through the parser into the result
// register, so the sustained rate is one byte per cycle while the output does
// not stall, and each result is registered before it is presented. The length counter
// is LENGTH_BITS wide; longer lengths saturate.

module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       frame_kind_o,
  output logic       last_of_frame_o,
  output logic       empty_frame_o
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             out_ready;
  logic             fire;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t res_out;

  assign fire = byte_valid && out_ready;

  wsd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .take_i      (fire),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_q)
  );

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign payload_byte_o  = res_out.payload_byte;
  assign frame_kind_o    = res_out.frame_kind;
  assign last_of_frame_o = res_out.last_of_frame;
  assign empty_frame_o   = res_out.empty_frame;

endmodule

`default_nettype wire

// ===== tb/sv/wsd_frame_checker.sv =====
`timescale 1ns / 1ps
// wsd_frame_checker: watches both request channels of the deframer, predicts results
// from the accepted byte stream and compares them field by field; depends on wsd_pkg

module wsd_frame_checker
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_kind_i,
  input  logic       last_of_frame_i,
  input  logic       empty_frame_i,
  output int         outstanding_o,
  output int         fail_count_o
);

  phase_e                 phase;
  logic [3:0]             opcode;
  logic                   masked;
  logic [2:0]             hdr_cnt;
  logic [LENGTH_BITS-1:0] remaining;
  logic [1:0]             pos;
  logic [7:0]             key [4];

  result_t deframed_q [$];

  function automatic bit finish_header(output result_t res);
    res = '0;
    pos = '0;
    if (remaining != '0) begin
      phase = PH_DATA;
      return 1'b0;
    end
    phase = PH_HDR0;
    // zero-length frames report on their last header byte
    if (opcode == OP_TEXT) begin
      res.last_of_frame = 1'b1;
      res.empty_frame   = 1'b1;
      return 1'b1;
    end
    if (opcode == OP_CLOSE) begin
      res.frame_kind    = 1'b1;
      res.last_of_frame = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit finish_length(output result_t res);
    res = '0;
    if (masked) begin
      hdr_cnt = '0;
      phase   = PH_MASK;
      return 1'b0;
    end
    return finish_header(res);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    logic [6:0] code;
    logic [7:0] data;
    res = '0;
    case (phase)
      PH_HDR1: begin
        code   = b[6:0];
        masked = b[7];
        if (code == LEN_CODE_EXT16 || code == LEN_CODE_EXT64) begin
          remaining = '0;
          hdr_cnt   = (code == LEN_CODE_EXT16) ? HDR_CNT_EXT16 : HDR_CNT_EXT64;
          phase     = PH_EXT;
          return 1'b0;
        end
        remaining = LENGTH_BITS'(code);
        return finish_length(res);
      end
      PH_EXT: begin
        // a length wider than the counter sticks at all ones
        if ((remaining >> (LENGTH_BITS - 8)) != '0) remaining = '1;
        else remaining = {remaining[LENGTH_BITS-9:0], b};
        if (hdr_cnt != '0) begin
          hdr_cnt = hdr_cnt - 3'd1;
          return 1'b0;
        end
        return finish_length(res);
      end
      PH_MASK: begin
        key[hdr_cnt[1:0]] = b;
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt < 3'd4) return 1'b0;
        hdr_cnt = '0;
        return finish_header(res);
      end
      PH_DATA: begin
        data = masked ? (b ^ key[pos]) : b;
        pos  = pos + 2'd1;
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) phase = PH_HDR0;
        if (opcode == OP_TEXT) begin
          res.payload_byte  = data;
          res.last_of_frame = (remaining == '0);
          return 1'b1;
        end
        if (opcode == OP_CLOSE && remaining == '0) begin
          res.frame_kind    = 1'b1;
          res.last_of_frame = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        opcode = b[3:0];
        phase  = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got_res;
    result_t want;
    if (!rst_ni) begin
      phase     = PH_HDR0;
      opcode    = '0;
      masked    = 1'b0;
      hdr_cnt   = '0;
      remaining = '0;
      pos       = '0;
      for (int k = 0; k < 4; k++) key[k] = '0;
      deframed_q.delete();
      outstanding_o = 0;
    end else begin
      // results trail their byte through the input and result registers, so check before predicting
      if (out_valid_i && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          $error("unexpected result: payload_byte %0h frame_kind %0b",
                 payload_byte_i, frame_kind_i,
                 " last_of_frame %0b empty_frame %0b", last_of_frame_i, empty_frame_i);
          fail_count_o++;
        end else begin
          want = deframed_q.pop_front();
          if (payload_byte_i !== want.payload_byte) begin
            $error("payload_byte expected %0h actual %0h", want.payload_byte, payload_byte_i);
            fail_count_o++;
          end
          if (frame_kind_i !== want.frame_kind) begin
            $error("frame_kind expected %0b actual %0b", want.frame_kind, frame_kind_i);
            fail_count_o++;
          end
          if (last_of_frame_i !== want.last_of_frame) begin
            $error("last_of_frame expected %0b actual %0b", want.last_of_frame, last_of_frame_i);
            fail_count_o++;
          end
          if (empty_frame_i !== want.empty_frame) begin
            $error("empty_frame expected %0b actual %0b", want.empty_frame, empty_frame_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(rx_byte_i, got_res)) deframed_q.insert(deframed_q.size(), got_res);
      end
      outstanding_o = deframed_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// tb_websocket_frame_deframer: drives framed byte streams into the deframer with random
// gaps and stalls; depends on wsd_pkg, websocket_frame_deframer and wsd_frame_checker

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int TARGET_BYTES    = 1150;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT     = 200000;

  // ping opcode stands in for a frame that is dropped
  localparam logic [3:0] OP_PING        = 4'h9;
  localparam logic [6:0] LEN_FORM_SHORT = 7'd0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic       frame_kind;
  logic       last_of_frame;
  logic       empty_frame;

  int outstanding;
  int fail_count;
  int sent_count;
  int cycle_count;
  bit tx_idles;
  bit rx_idles;
  bit hold_off_req;

  websocket_frame_deframer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte),
    .frame_kind_o   (frame_kind),
    .last_of_frame_o(last_of_frame),
    .empty_frame_o  (empty_frame)
  );

  wsd_frame_checker #(
    .LENGTH_BITS(LENGTH_BITS_DEF)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_i (payload_byte),
    .frame_kind_i   (frame_kind),
    .last_of_frame_i(last_of_frame),
    .empty_frame_i  (empty_frame),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= rx_idles && ($urandom_range(0, 99) < 19);
      end
    end
  end

  // entered and left at a falling edge; valid stays high for the next request
  task automatic push_byte(input logic [7:0] b);
    while (tx_idles && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_frame(input logic [3:0] op, input logic masked, input logic [6:0] form,
                            input logic [63:0] len, input logic [31:0] mask_key,
                            input int body_len);
    int i;
    push_byte({4'($urandom_range(0, 15)), op});
    if (form == LEN_CODE_EXT16) begin
      push_byte({masked, LEN_CODE_EXT16});
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else if (form == LEN_CODE_EXT64) begin
      push_byte({masked, LEN_CODE_EXT64});
      for (i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
    end else begin
      push_byte({masked, len[6:0]});
    end
    if (masked) begin
      for (i = 3; i >= 0; i--) push_byte(mask_key[8*i +: 8]);
    end
    for (i = 0; i < body_len; i++) push_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [3:0]  op;
    logic        masked;
    logic [6:0]  form;
    logic [31:0] mask_key;
    int          len;
    int          pick;
    bit          hold_done;
    bit          quiet_done;
    bit          pause_done;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    tx_idles     = 1'b1;
    rx_idles     = 1'b1;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    quiet_done   = 1'b0;
    pause_done   = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty text and close, masked text, close with payload,
    // empty text through the 16-bit length, and a frame that is dropped
    send_frame(OP_TEXT, 1'b0, LEN_FORM_SHORT, 64'd0, 32'h0, 0);
    send_frame(OP_CLOSE, 1'b0, LEN_FORM_SHORT, 64'd0, 32'h0, 0);
    send_frame(OP_TEXT, 1'b1, LEN_FORM_SHORT, 64'd3, 32'hFF00A55A, 3);
    send_frame(OP_CLOSE, 1'b0, LEN_FORM_SHORT, 64'd1, 32'h0, 1);
    send_frame(OP_TEXT, 1'b0, LEN_CODE_EXT16, 64'd0, 32'h0, 0);
    send_frame(OP_PING, 1'b0, LEN_FORM_SHORT, 64'd1, 32'h0, 1);

    while (sent_count < TARGET_BYTES) begin
      if (!hold_done && sent_count >= 350) begin
        hold_done    = 1'b1;
        hold_off_req = 1'b1;
        send_frame(OP_TEXT, 1'b1, LEN_FORM_SHORT, 64'd40, $urandom, 40);
      end
      if (!quiet_done && sent_count >= 550) begin
        quiet_done = 1'b1;
        tx_idles   = 1'b0;
        rx_idles   = 1'b0;
      end
      if (!pause_done && sent_count >= 800) begin
        pause_done = 1'b1;
        wait_drained();
        tx_idles = 1'b1;
        rx_idles = 1'b1;
      end

      pick = $urandom_range(0, 99);
      op   = (pick < 50) ? OP_TEXT : (pick < 70) ? OP_CLOSE : 4'($urandom_range(0, 15));
      masked = 1'($urandom_range(0, 1));

      pick = $urandom_range(0, 99);
      if (pick < 10) len = 0;
      else if (pick < 85) len = $urandom_range(1, 16);
      else if (pick < 97) len = $urandom_range(17, 125);
      else len = $urandom_range(126, 300);

      pick = $urandom_range(0, 99);
      if (len >= 126) form = (pick < 50) ? LEN_CODE_EXT16 : LEN_CODE_EXT64;
      else if (pick < 80) form = LEN_FORM_SHORT;
      else if (pick < 90) form = LEN_CODE_EXT16;
      else form = LEN_CODE_EXT64;

      pick = $urandom_range(0, 99);
      if (pick < 10) mask_key = 32'h0;
      else if (pick < 20) mask_key = 32'hFFFFFFFF;
      else mask_key = $urandom;

      send_frame(op, masked, form, 64'(len), mask_key, len);
    end

    // largest 64-bit length closes the stream: its payload never ends
    send_frame(OP_TEXT, 1'($urandom_range(0, 1)), LEN_CODE_EXT64, 64'hFFFFFFFFFFFFFFFF,
               $urandom, 24);

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
